// File: hdl/cgnm_pkg.sv
package cgnm_pkg;

    localparam int DEF_TABLE_DEPTH = 32;

    localparam int CMD_W     = 2;
    localparam int CLASS_W   = 8;
    localparam int POS_W     = 16;
    localparam int DIFF_W    = POS_W + 1;
    localparam int SQ_W      = 32;
    localparam int ERR_W     = 34;
    localparam int IDX_OUT_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR_LOCAL = 2'd0,
        CMD_ADD_GLOBAL  = 2'd1,
        CMD_ADD_LOCAL   = 2'd2,
        CMD_ASSOCIATE   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_pos;

    typedef struct packed {
        logic [CLASS_W-1:0] class_id;
        t_pos               pos;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GLOAD,
        S_GLATCH,
        S_LREAD,
        S_LCHK,
        S_DIST,
        S_EMIT
    } t_state;

endpackage

// File: hdl/cgnm_if.sv
interface cgnm_in_if;
    logic                              valid;
    logic                              ready;
    logic [cgnm_pkg::CMD_W-1:0]        command;
    logic [cgnm_pkg::CLASS_W-1:0]      class_id;
    logic signed [cgnm_pkg::POS_W-1:0] pos_x;
    logic signed [cgnm_pkg::POS_W-1:0] pos_y;
    logic signed [cgnm_pkg::POS_W-1:0] pos_z;

    modport source (output valid, command, class_id, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, command, class_id, pos_x, pos_y, pos_z, output ready);
endinterface

interface cgnm_out_if;
    logic                            valid;
    logic                            ready;
    logic [cgnm_pkg::IDX_OUT_W-1:0]  global_index;
    logic [cgnm_pkg::IDX_OUT_W-1:0]  local_index;
    logic                            matched;
    logic [cgnm_pkg::ERR_W-1:0]      sq_error;
    logic                            last;

    modport source (output valid, global_index, local_index, matched, sq_error, last,
                    input ready);
    modport sink   (input valid, global_index, local_index, matched, sq_error, last,
                    output ready);
endinterface

// File: hdl/cgnm_ram.sv
module cgnm_ram #(
    parameter int WIDTH = cgnm_pkg::ENTRY_W,
    parameter int DEPTH = cgnm_pkg::DEF_TABLE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: hdl/cgnm_dist.sv
// squared distance, one axis through the multiplier per cycle
module cgnm_dist (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  cgnm_pkg::t_pos             i_a,
    input  cgnm_pkg::t_pos             i_b,
    output logic                       o_done,
    output logic [cgnm_pkg::ERR_W-1:0] o_dist
);

    cgnm_pkg::t_pos                     r_a;
    cgnm_pkg::t_pos                     r_b;
    logic [1:0]                         r_axis;
    logic                               r_busy;
    logic                               r_done;
    logic [cgnm_pkg::SQ_W-1:0]          r_sq;
    logic [cgnm_pkg::ERR_W-1:0]         r_acc;

    logic signed [cgnm_pkg::POS_W-1:0]  a_sel;
    logic signed [cgnm_pkg::POS_W-1:0]  b_sel;
    logic signed [cgnm_pkg::DIFF_W-1:0] diff;
    logic signed [2*cgnm_pkg::DIFF_W-1:0] prod;

    always_comb begin
        case (r_axis)
            2'd0: begin
                a_sel = r_a.x;
                b_sel = r_b.x;
            end
            2'd1: begin
                a_sel = r_a.y;
                b_sel = r_b.y;
            end
            2'd2: begin
                a_sel = r_a.z;
                b_sel = r_b.z;
            end
            default: begin
                a_sel = '0;
                b_sel = '0;
            end
        endcase
        diff = cgnm_pkg::DIFF_W'(a_sel) - cgnm_pkg::DIFF_W'(b_sel);
        prod = diff * diff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_axis <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_axis <= '0;
            end else if (r_busy) begin
                r_axis <= r_axis + 2'd1;
                if (r_axis == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands and datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_sq  <= '0;
            r_acc <= '0;
        end else if (r_busy) begin
            r_sq  <= prod[cgnm_pkg::SQ_W-1:0];
            r_acc <= r_acc + cgnm_pkg::ERR_W'(r_sq);
        end
    end

    assign o_done = r_done;
    assign o_dist = r_acc;

endmodule

// File: hdl/class_gated_nearest_match_top.sv
// clear and add words are taken only while idle, and the input stays ready for the next word
// associate: each global entry is loaded, latched and emitted; each local entry is read and its class
// compared, and when the classes agree it also goes through the shared multiplier one axis at a time;
// the scan speed is set by the single squared-distance unit and the table read ports
// reset: counts, ready flags, sequencer and output valid clear; table contents stay as written
module class_gated_nearest_match_top #(
    parameter int TABLE_DEPTH = cgnm_pkg::DEF_TABLE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cgnm_in_if.sink      i_in,
    cgnm_out_if.source   o_out
);

    // index into a table, and a count that can reach the depth itself
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // sequencer state and its next value
    cgnm_pkg::t_state r_state, n_state;

    // table bookkeeping
    logic [CW-1:0] r_gc, n_gc;
    logic [CW-1:0] r_lc, n_lc;
    logic          r_g_rdy, n_g_rdy;
    logic          r_l_rdy, n_l_rdy;

    // scan position and the global entry under test
    logic [IW-1:0]   r_g, n_g;
    logic [IW-1:0]   r_l, n_l;
    cgnm_pkg::t_entry r_gent, n_gent;

    // running best match for the current global entry
    logic                       r_found, n_found;
    logic [IW-1:0]              r_best_idx, n_best_idx;
    logic [cgnm_pkg::ERR_W-1:0] r_best_err, n_best_err;

    // output register, parts the scan from a stalled sink
    logic                           r_out_valid, n_out_valid;
    logic [cgnm_pkg::IDX_OUT_W-1:0] r_out_gidx, n_out_gidx;
    logic [cgnm_pkg::IDX_OUT_W-1:0] r_out_lidx, n_out_lidx;
    logic                           r_out_matched, n_out_matched;
    logic [cgnm_pkg::ERR_W-1:0]     r_out_err, n_out_err;
    logic                           r_out_last, n_out_last;

    // table ports
    logic                          g_we, l_we;
    logic [IW-1:0]                 wr_addr;
    logic [cgnm_pkg::ENTRY_W-1:0]  wr_data;
    logic [cgnm_pkg::ENTRY_W-1:0]  g_rdata, l_rdata;
    cgnm_pkg::t_entry              l_ent;

    // distance unit
    logic                       dist_start;
    logic                       dist_done;
    logic [cgnm_pkg::ERR_W-1:0] dist_val;

    logic          in_take;
    logic          l_last;
    logic          g_last;
    cgnm_pkg::t_entry in_ent;

    assign in_take = i_in.valid && i_in.ready;
    assign l_ent   = l_rdata;
    assign l_last  = (CW'(r_l) + CW'(1)) == r_lc;
    assign g_last  = (CW'(r_g) + CW'(1)) == r_gc;

    assign in_ent.class_id = i_in.class_id;
    assign in_ent.pos.x    = i_in.pos_x;
    assign in_ent.pos.y    = i_in.pos_y;
    assign in_ent.pos.z    = i_in.pos_z;
    assign wr_data         = in_ent;

    cgnm_ram #(
        .WIDTH (cgnm_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_global_ram (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (r_g),
        .o_rdata (g_rdata)
    );

    cgnm_ram #(
        .WIDTH (cgnm_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_local_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (r_l),
        .o_rdata (l_rdata)
    );

    cgnm_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dist_start),
        .i_a     (r_gent.pos),
        .i_b     (l_ent.pos),
        .o_done  (dist_done),
        .o_dist  (dist_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cgnm_pkg::S_IDLE;
            r_gc        <= '0;
            r_lc        <= '0;
            r_g_rdy     <= 1'b0;
            r_l_rdy     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gc        <= n_gc;
            r_lc        <= n_lc;
            r_g_rdy     <= n_g_rdy;
            r_l_rdy     <= n_l_rdy;
            r_out_valid <= n_out_valid;
        end
    end

    // scan and result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_g           <= n_g;
        r_l           <= n_l;
        r_gent        <= n_gent;
        r_found       <= n_found;
        r_best_idx    <= n_best_idx;
        r_best_err    <= n_best_err;
        r_out_gidx    <= n_out_gidx;
        r_out_lidx    <= n_out_lidx;
        r_out_matched <= n_out_matched;
        r_out_err     <= n_out_err;
        r_out_last    <= n_out_last;
    end

    always_comb begin
        n_state       = r_state;
        n_gc          = r_gc;
        n_lc          = r_lc;
        n_g_rdy       = r_g_rdy;
        n_l_rdy       = r_l_rdy;
        n_g           = r_g;
        n_l           = r_l;
        n_gent        = r_gent;
        n_found       = r_found;
        n_best_idx    = r_best_idx;
        n_best_err    = r_best_err;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_gidx    = r_out_gidx;
        n_out_lidx    = r_out_lidx;
        n_out_matched = r_out_matched;
        n_out_err     = r_out_err;
        n_out_last    = r_out_last;
        g_we          = 1'b0;
        l_we          = 1'b0;
        wr_addr       = '0;
        dist_start    = 1'b0;

        case (r_state)
            cgnm_pkg::S_IDLE: begin
                if (in_take) begin
                    case (cgnm_pkg::t_cmd'(i_in.command))
                        cgnm_pkg::CMD_CLEAR_LOCAL: begin
                            n_lc    = '0;
                            n_l_rdy = 1'b1;
                        end
                        cgnm_pkg::CMD_ADD_GLOBAL: begin
                            // a full table drops the word
                            if (r_gc < CW'(TABLE_DEPTH)) begin
                                g_we    = 1'b1;
                                wr_addr = r_gc[IW-1:0];
                                n_gc    = r_gc + CW'(1);
                            end
                            n_g_rdy = 1'b1;
                        end
                        cgnm_pkg::CMD_ADD_LOCAL: begin
                            if (r_lc < CW'(TABLE_DEPTH)) begin
                                l_we    = 1'b1;
                                wr_addr = r_lc[IW-1:0];
                                n_lc    = r_lc + CW'(1);
                            end
                            n_l_rdy = 1'b1;
                        end
                        cgnm_pkg::CMD_ASSOCIATE: begin
                            // nothing to report until both frames are prepared and the global table is not empty
                            if (r_g_rdy && r_l_rdy && (r_gc != '0)) begin
                                n_g     = '0;
                                n_state = cgnm_pkg::S_GLOAD;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // global read address is r_g; the registered read data is latched in S_GLATCH
            cgnm_pkg::S_GLOAD: begin
                n_state = cgnm_pkg::S_GLATCH;
            end

            cgnm_pkg::S_GLATCH: begin
                n_gent     = g_rdata;
                n_l        = '0;
                n_found    = 1'b0;
                n_best_idx = '0;
                n_best_err = '0;
                n_state    = (r_lc == '0) ? cgnm_pkg::S_EMIT : cgnm_pkg::S_LREAD;
            end

            cgnm_pkg::S_LREAD: begin
                n_state = cgnm_pkg::S_LCHK;
            end

            // class gate: only same-class entries go through the multiplier
            cgnm_pkg::S_LCHK: begin
                if (l_ent.class_id == r_gent.class_id) begin
                    dist_start = 1'b1;
                    n_state    = cgnm_pkg::S_DIST;
                end else if (l_last) begin
                    n_state = cgnm_pkg::S_EMIT;
                end else begin
                    n_l     = r_l + IW'(1);
                    n_state = cgnm_pkg::S_LREAD;
                end
            end

            cgnm_pkg::S_DIST: begin
                if (dist_done) begin
                    // strict less-than keeps the lowest index on ties
                    if (!r_found || (dist_val < r_best_err)) begin
                        n_found    = 1'b1;
                        n_best_idx = r_l;
                        n_best_err = dist_val;
                    end
                    if (l_last) begin
                        n_state = cgnm_pkg::S_EMIT;
                    end else begin
                        n_l     = r_l + IW'(1);
                        n_state = cgnm_pkg::S_LREAD;
                    end
                end
            end

            // wait for the output register to free up, then hand over the result
            cgnm_pkg::S_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_gidx    = cgnm_pkg::IDX_OUT_W'(r_g);
                    n_out_lidx    = cgnm_pkg::IDX_OUT_W'(r_best_idx);
                    n_out_matched = r_found;
                    n_out_err     = r_best_err;
                    n_out_last    = g_last;
                    if (g_last) begin
                        n_state = cgnm_pkg::S_IDLE;
                    end else begin
                        n_g     = r_g + IW'(1);
                        n_state = cgnm_pkg::S_GLOAD;
                    end
                end
            end

            default: begin
                n_state = cgnm_pkg::S_IDLE;
            end
        endcase
    end

    // one word at a time: new words only between associate scans
    assign i_in.ready = (r_state == cgnm_pkg::S_IDLE);

    assign o_out.valid        = r_out_valid;
    assign o_out.global_index = r_out_gidx;
    assign o_out.local_index  = r_out_lidx;
    assign o_out.matched      = r_out_matched;
    assign o_out.sq_error     = r_out_err;
    assign o_out.last         = r_out_last;

    // counts never pass the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gc <= CW'(TABLE_DEPTH)) && (r_lc <= CW'(TABLE_DEPTH)))
        else $error("table count beyond depth");

    // the distance unit only finishes while the sequencer waits for it
    a_dist_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dist_done |-> (r_state == cgnm_pkg::S_DIST))
        else $error("distance result with no waiting sequencer");

    // the local scan stays inside the filled part of the table
    a_local_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == cgnm_pkg::S_LCHK) || (r_state == cgnm_pkg::S_DIST))
            |-> (CW'(r_l) < r_lc))
        else $error("local scan past fill count");

    // unmatched results carry zero index and zero error
    a_unmatched_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_matched) |-> ((r_out_lidx == '0) && (r_out_err == '0)))
        else $error("unmatched result with nonzero payload");

endmodule
